// File: hdl/lcdr_pkg.sv
package lcdr_pkg;

  // Port expander bit positions and masks.
  localparam logic [7:0] BIT_BACKLIGHT = 8'h08;
  localparam logic [7:0] BIT_ENABLE    = 8'h04;
  localparam logic [7:0] BIT_SELECT    = 8'h01;
  localparam logic [7:0] NIBBLE_MASK   = 8'hF0;

  // Display command and character codes.
  localparam logic [7:0] CMD_ROW0_ADDR = 8'h80;
  localparam logic [7:0] CMD_ROW1_ADDR = 8'hC0;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;

  // Expander byte counts per transfer.
  localparam logic [2:0] BC_NIBBLE = 3'd2;
  localparam logic [2:0] BC_FULL   = 3'd4;

  // Start-up sequence: four nibble writes followed by five full commands.
  localparam int unsigned INIT_LEN     = 9;
  localparam int unsigned INIT_NIBBLES = 4;
  localparam int unsigned INIT_IW      = 4;

  // One input item.
  typedef struct packed {
    logic       op;
    logic       row;
    logic [7:0] character;
    logic       end_of_text;
  } lcdr_in_t;

  // One result item, one display transfer.
  typedef struct packed {
    logic [7:0] lcd_value;
    logic       register_select;
    logic [7:0] expander_first;
    logic [7:0] expander_second;
    logic [7:0] expander_third;
    logic [7:0] expander_fourth;
    logic [2:0] byte_count;
    logic       last;
  } lcdr_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic init_emit;
    logic rd;
    logic addr_emit;
    logic line_emit;
    logic line_last;
    logic line_done;
    logic clear_fill;
  } lcdr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_init;
    logic is_end;
    logic differs;
  } lcdr_status_t;

  // Byte sent at each step of the start-up sequence.
  function automatic logic [7:0] init_value(input logic [INIT_IW-1:0] k);
    logic [7:0] v;
    unique case (k)
      4'd0, 4'd1, 4'd2: v = 8'h30;
      4'd3:             v = 8'h20;
      4'd4:             v = 8'h28;
      4'd5:             v = 8'h08;
      4'd6:             v = 8'h01;
      4'd7:             v = 8'h06;
      4'd8:             v = 8'h0C;
      default:          v = 8'h00;
    endcase
    return v;
  endfunction

  // Splits one transfer into its expander bytes.
  function automatic lcdr_out_t make_transfer(input logic [7:0] value, input logic rs,
                                              input logic nibble_only, input logic last);
    logic [7:0] base;
    logic [7:0] hi;
    logic [7:0] lo;
    lcdr_out_t  r;
    base = BIT_BACKLIGHT | (rs ? BIT_SELECT : 8'h00);
    hi   = (value & NIBBLE_MASK) | base;
    lo   = {value[3:0], 4'h0} | base;
    r.lcd_value       = value;
    r.register_select = rs;
    r.expander_first  = hi | BIT_ENABLE;
    r.expander_second = hi & ~BIT_ENABLE;
    r.expander_third  = nibble_only ? 8'h00 : (lo | BIT_ENABLE);
    r.expander_fourth = nibble_only ? 8'h00 : (lo & ~BIT_ENABLE);
    r.byte_count      = nibble_only ? BC_NIBBLE : BC_FULL;
    r.last            = last;
    return r;
  endfunction

endpackage

// File: hdl/char_lcd_line_refresher_unit.sv
// Character LCD line refresher, 4-bit bus through an 8-bit port expander.
// Input channel: an item is taken at a clock edge with start high and busy
// low. A text character is stored as it is taken and busy stays low, so
// characters can be sent on every cycle. An end of text (end flag or a
// zero character) starts a compare of the padded line against the row's
// shadow copy, one memory read per character, with busy high. If the line
// differs, LINE_CHARS + 1 transfers follow, one per cycle, the row address
// first, shown after the compare and its wait state, and the shadow row is
// rewritten as they go; busy stays high through the compare and transfers.
// An init item yields nine transfers, one per cycle, the first shown once
// the controller is in its init state and the output register has taken it.
// Result channel: each transfer is shown on result_o for one cycle while
// strobe_o is high; the receiver cannot stall, and the final transfer of a
// run has last set. busy falls in the cycle after the final transfer is
// scheduled, so the next item may be taken as that transfer is shown.
// Reset clears the control state and marks both shadow rows as invalid, so
// the first line written to each row is always sent; no clearing pass runs.
module char_lcd_line_refresher_unit import lcdr_pkg::*; #(
  parameter int unsigned LINE_CHARS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  lcdr_in_t  item_i,
  output logic      strobe_o,
  output lcdr_out_t result_o
);

  localparam int unsigned IW = $clog2(LINE_CHARS + 1);

  lcdr_cmd_t     cmd;
  lcdr_status_t  status;
  logic [IW-1:0] idx;

  // Sequencing of compare and emission runs.
  lcdr_ctrl #(
    .LINE_CHARS(LINE_CHARS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .status_i(status),
    .cmd_o   (cmd),
    .idx_o   (idx),
    .busy_o  (busy)
  );

  // Line storage, shadow rows and transfer formatting.
  lcdr_datapath #(
    .LINE_CHARS(LINE_CHARS)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cmd_i   (cmd),
    .idx_i   (idx),
    .status_o(status),
    .strobe_o(strobe_o),
    .result_o(result_o)
  );

  // A transfer is only produced by a run that was in progress in the previous cycle.
  a_strobe_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("transfer strobe outside of a run");

  // The final transfer of a run is never directly followed by another transfer.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_o.last) |=> !strobe_o)
    else $error("transfer directly after the final one of a run");

  // A run only begins when an item was offered.
  a_run_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("run began without an item");

endmodule

// File: hdl/lcdr_ctrl.sv
module lcdr_ctrl import lcdr_pkg::*; #(
  parameter int unsigned LINE_CHARS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  lcdr_status_t                         status_i,
  output lcdr_cmd_t                            cmd_o,
  output logic [$clog2(LINE_CHARS+1)-1:0]      idx_o,
  output logic                                 busy_o
);

  localparam int unsigned IW = $clog2(LINE_CHARS + 1);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_INIT     = 6'b000010,
    S_CMP      = 6'b000100,
    S_CMP_WAIT = 6'b001000,
    S_ADDR     = 6'b010000,
    S_EMIT     = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;

  // Next state, index counter and datapath commands.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          idx_d        = '0;
          if (status_i.is_init) begin
            state_d = S_INIT;
          end else if (status_i.is_end) begin
            state_d = S_CMP;
          end
        end
      end
      S_INIT: begin
        cmd_o.init_emit = 1'b1;
        if (idx_q == IW'(INIT_LEN - 1)) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_CMP: begin
        cmd_o.rd = 1'b1;
        if (idx_q == IW'(LINE_CHARS - 1)) begin
          state_d = S_CMP_WAIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_CMP_WAIT: begin
        idx_d = '0;
        if (status_i.differs) begin
          state_d = S_ADDR;
        end else begin
          cmd_o.clear_fill = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_ADDR: begin
        cmd_o.addr_emit = 1'b1;
        cmd_o.rd        = 1'b1;
        idx_d           = idx_q + 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.line_emit = 1'b1;
        if (idx_q == IW'(LINE_CHARS)) begin
          cmd_o.line_last = 1'b1;
          cmd_o.line_done = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          idx_d    = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign idx_o  = idx_q;
  assign busy_o = (state_q != S_IDLE);

endmodule

// File: hdl/lcdr_datapath.sv
module lcdr_datapath import lcdr_pkg::*; #(
  parameter int unsigned LINE_CHARS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lcdr_in_t                             item_i,
  input  lcdr_cmd_t                            cmd_i,
  input  logic [$clog2(LINE_CHARS+1)-1:0]      idx_i,
  output lcdr_status_t                         status_o,
  output logic                                 strobe_o,
  output lcdr_out_t                            result_o
);

  localparam int unsigned IW  = $clog2(LINE_CHARS + 1);
  localparam int unsigned AW  = $clog2(LINE_CHARS);
  localparam int unsigned SAW = $clog2(2 * LINE_CHARS);

  // Text assembly memory and shadow copy of both rows.
  logic [7:0] asm_mem    [LINE_CHARS];
  logic [7:0] shadow_mem [2*LINE_CHARS];

  logic [IW-1:0]  fill_q;
  logic [1:0]     row_valid_q;
  logic           row_q;
  logic           diff_q;
  logic           rd_vld_q;
  logic [AW-1:0]  pos_q;
  logic [7:0]     asm_rdata_q;
  logic [7:0]     sh_rdata_q;
  logic           strobe_q, strobe_d;
  lcdr_out_t      out_q, out_d;

  logic           store_char;
  logic [AW-1:0]  rd_addr;
  logic [SAW-1:0] sh_rd_addr;
  logic [SAW-1:0] sh_wr_addr;
  logic [7:0]     line_char;
  logic [7:0]     shadow_char;
  logic           mismatch;

  // Item decode for the controller.
  assign status_o.is_init = item_i.op;
  assign status_o.is_end  = !item_i.op && (item_i.end_of_text || (item_i.character == 8'h00));

  assign store_char = cmd_i.accept && !status_o.is_init && !status_o.is_end &&
                      (fill_q < IW'(LINE_CHARS));

  // Read and write addresses; row one sits after row zero in the shadow.
  assign rd_addr    = idx_i[AW-1:0];
  assign sh_rd_addr = SAW'(rd_addr) + (row_q ? SAW'(LINE_CHARS) : SAW'(0));
  assign sh_wr_addr = SAW'(pos_q) + (row_q ? SAW'(LINE_CHARS) : SAW'(0));

  // Padded line character and shadow character at the position just read.
  assign line_char   = (IW'(pos_q) < fill_q) ? asm_rdata_q : CHAR_SPACE;
  assign shadow_char = row_valid_q[row_q] ? sh_rdata_q : 8'h00;
  assign mismatch    = rd_vld_q && (line_char != shadow_char);

  assign status_o.differs = diff_q || mismatch;

  // Memory writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (store_char) begin
      asm_mem[fill_q[AW-1:0]] <= item_i.character;
    end
    if (cmd_i.line_emit) begin
      shadow_mem[sh_wr_addr] <= line_char;
    end
    if (cmd_i.rd) begin
      asm_rdata_q <= asm_mem[rd_addr];
      sh_rdata_q  <= shadow_mem[sh_rd_addr];
      pos_q       <= rd_addr;
    end
  end

  // Result selection for the next output cycle.
  always_comb begin
    strobe_d = cmd_i.init_emit || cmd_i.addr_emit || cmd_i.line_emit;
    out_d    = out_q;
    if (cmd_i.init_emit) begin
      out_d = make_transfer(init_value(idx_i[INIT_IW-1:0]), 1'b0,
                            (idx_i < IW'(INIT_NIBBLES)), (idx_i == IW'(INIT_LEN - 1)));
    end else if (cmd_i.addr_emit) begin
      out_d = make_transfer(row_q ? CMD_ROW1_ADDR : CMD_ROW0_ADDR, 1'b0, 1'b0, 1'b0);
    end else if (cmd_i.line_emit) begin
      out_d = make_transfer(line_char, 1'b1, 1'b0, cmd_i.line_last);
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Control state: fill count, row validity, selected row, compare flag, read flag and strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      row_valid_q <= '0;
      row_q       <= 1'b0;
      diff_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      strobe_q    <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd;
      strobe_q <= strobe_d;
      // The compare flag starts afresh with each end of text.
      if (cmd_i.accept && status_o.is_end) begin
        diff_q <= 1'b0;
      end else begin
        diff_q <= diff_q || mismatch;
      end
      if (cmd_i.accept) begin
        if (status_o.is_init) begin
          row_valid_q <= '0;
          fill_q      <= '0;
        end else if (status_o.is_end) begin
          row_q <= item_i.row;
        end else if (store_char) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.clear_fill) begin
        fill_q <= '0;
      end
      if (cmd_i.line_done) begin
        fill_q             <= '0;
        row_valid_q[row_q] <= 1'b1;
      end
    end
  end

  assign strobe_o = strobe_q;
  assign result_o = out_q;

endmodule
